// File: hw/rtl/qte_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the quaternion-to-Euler block.
package qte_pkg;

  // CORDIC iteration count default, legal range 12 to 24
  localparam int CordicStepsDef = 16;

  // Widths
  localparam int CntW  = 5;   // holds up to 31 (sqrt steps, CORDIC steps <= 24)
  localparam int CompW = 32;  // clamped Q2.30 component
  localparam int AccW  = 64;  // product accumulators, Q.60
  localparam int ArgW  = 34;  // atan2 arguments after the >> 30
  localparam int SqW   = 61;  // square-root radicand and result register
  localparam int CxW   = 40;  // CORDIC x / y
  localparam int ZW    = 34;  // CORDIC angle, 2^-30 rad
  localparam int UPrW  = 48;  // |angle| * units-per-radian
  localparam int AngW  = 16;

  localparam int NumProd    = 10;
  localparam int SqrtSteps  = 31;
  localparam int UnitsPerRad = 10430;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_PREP,
    S_SQ,
    S_RINIT,
    S_SQRT,
    S_CINIT,
    S_CSTEP,
    S_UMUL,
    S_USTORE,
    S_OUT
  } state_e;

  // Which angle the shared CORDIC is working on
  typedef enum logic [1:0] {
    SEL_ROLL,
    SEL_PITCH,
    SEL_YAW
  } angle_e;

  // Product sequence of the shared multiplier
  typedef enum logic [3:0] {
    P_WW, P_XX, P_YY, P_ZZ, P_YZ, P_WX, P_XY, P_WZ, P_XZ, P_WY
  } prod_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic            load;
    logic            mul_en;
    prod_e           mul_idx;
    logic            prep;
    logic            sq;
    logic            sqrt_init;
    logic            sqrt_step;
    logic            cinit;
    logic            cstep;
    logic [CntW-1:0] step_idx;
    angle_e          sel;
    logic            umul;
    logic            ustore;
    logic            out_load;
  } cmd_t;

  // round(atan(2^-i) * 2^30)
  function automatic logic signed [ZW-1:0] atan_tab(input logic [CntW-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = 34'sd843314857;
      5'd1:    v = 34'sd497837829;
      5'd2:    v = 34'sd263043837;
      5'd3:    v = 34'sd133525159;
      5'd4:    v = 34'sd67021687;
      5'd5:    v = 34'sd33543516;
      5'd6:    v = 34'sd16775851;
      5'd7:    v = 34'sd8388437;
      5'd8:    v = 34'sd4194283;
      5'd9:    v = 34'sd2097149;
      5'd10:   v = 34'sd1048576;
      5'd11:   v = 34'sd524288;
      5'd12:   v = 34'sd262144;
      5'd13:   v = 34'sd131072;
      5'd14:   v = 34'sd65536;
      5'd15:   v = 34'sd32768;
      5'd16:   v = 34'sd16384;
      5'd17:   v = 34'sd8192;
      5'd18:   v = 34'sd4096;
      5'd19:   v = 34'sd2048;
      5'd20:   v = 34'sd1024;
      5'd21:   v = 34'sd512;
      5'd22:   v = 34'sd256;
      5'd23:   v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/qte_ctrl.sv
// Sequencing state machine for the quaternion-to-Euler block.
module qte_ctrl import qte_pkg::*; #(
  parameter int CordicSteps = CordicStepsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_kind_i,
  output logic in_stall_o,
  input  logic out_stall_i,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  angle_e          sel_q, sel_d;
  logic            out_valid_q, out_valid_d;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      sel_q       <= SEL_ROLL;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.sel   = sel_q;
    in_stall_o  = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = in_kind_i ? S_OUT : S_MUL;
        end
      end
      S_MUL: begin
        // one product per cycle; each product is registered and then accumulated
        if (cnt_q < CntW'(NumProd)) begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_idx = prod_e'(cnt_q[3:0]);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(NumProd)) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_SQ;
      end
      S_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = S_RINIT;
      end
      S_RINIT: begin
        cmd_o.sqrt_init = 1'b1;
        cnt_d           = '0;
        state_d         = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CntW'(SqrtSteps - 1)) begin
          sel_d   = SEL_ROLL;
          state_d = S_CINIT;
        end
      end
      S_CINIT: begin
        cmd_o.cinit = 1'b1;
        cnt_d       = '0;
        state_d     = S_CSTEP;
      end
      S_CSTEP: begin
        cmd_o.cstep    = 1'b1;
        cmd_o.step_idx = cnt_q;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(CordicSteps - 1)) begin
          state_d = S_UMUL;
        end
      end
      S_UMUL: begin
        cmd_o.umul = 1'b1;
        state_d    = S_USTORE;
      end
      S_USTORE: begin
        cmd_o.ustore = 1'b1;
        case (sel_q)
          SEL_ROLL:  sel_d = SEL_PITCH;
          SEL_PITCH: sel_d = SEL_YAW;
          default:   sel_d = SEL_ROLL;
        endcase
        state_d = (sel_q == SEL_YAW) ? S_OUT : S_CINIT;
      end
      S_OUT: begin
        // load the output register once it is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/qte_dp.sv
// Datapath: shared multiplier, square root, shared CORDIC, angle scaling and calibration.
module qte_dp import qte_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  input  logic                    in_kind_i,
  input  logic signed [31:0]      in_q_w_i,
  input  logic signed [31:0]      in_q_x_i,
  input  logic signed [31:0]      in_q_y_i,
  input  logic signed [31:0]      in_q_z_i,
  output logic signed [AngW-1:0]  roll_angle_o,
  output logic signed [AngW-1:0]  pitch_angle_o,
  output logic signed [AngW-1:0]  yaw_angle_o
);

  localparam logic signed [CompW-1:0] OneQ30 = CompW'(64'sd1073741824);
  localparam logic signed [ArgW-1:0]  OneArg = ArgW'(64'sd1073741824);

  function automatic logic signed [CompW-1:0] clamp_comp(input logic signed [31:0] v);
    logic signed [CompW-1:0] r;
    if (v > OneQ30) r = OneQ30;
    else if (v < -OneQ30) r = -OneQ30;
    else r = v;
    return r;
  endfunction

  logic                    kind_q;
  logic signed [CompW-1:0] w_q, x_q, y_q, z_q;

  // Capture and clamp the transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_kind_i;
      w_q    <= clamp_comp(in_q_w_i);
      x_q    <= clamp_comp(in_q_x_i);
      y_q    <= clamp_comp(in_q_y_i);
      z_q    <= clamp_comp(in_q_z_i);
    end
  end

  // Shared multiplier operand select
  logic signed [CompW-1:0] ma, mb;
  always_comb begin
    case (cmd_i.mul_idx)
      P_WW:    begin ma = w_q; mb = w_q; end
      P_XX:    begin ma = x_q; mb = x_q; end
      P_YY:    begin ma = y_q; mb = y_q; end
      P_ZZ:    begin ma = z_q; mb = z_q; end
      P_YZ:    begin ma = y_q; mb = z_q; end
      P_WX:    begin ma = w_q; mb = x_q; end
      P_XY:    begin ma = x_q; mb = y_q; end
      P_WZ:    begin ma = w_q; mb = z_q; end
      P_XZ:    begin ma = x_q; mb = z_q; end
      default: begin ma = w_q; mb = y_q; end
    endcase
  end

  logic signed [AccW-1:0] prod_q;
  prod_e                  acc_idx_q;
  logic                   acc_en_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= ma * mb;
    end
    acc_idx_q <= cmd_i.mul_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_en_q <= 1'b0;
    end else begin
      acc_en_q <= cmd_i.mul_en;
    end
  end

  // Accumulate the five atan2 / asin arguments in Q.60
  logic signed [AccW-1:0] acc_ry_q, acc_rx_q, acc_yy_q, acc_yx_q, acc_s_q;
  logic signed [AccW-1:0] prod2;
  assign prod2 = prod_q <<< 1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      acc_ry_q <= '0;
      acc_rx_q <= '0;
      acc_yy_q <= '0;
      acc_yx_q <= '0;
      acc_s_q  <= '0;
    end else if (acc_en_q) begin
      case (acc_idx_q)
        P_WW: begin acc_rx_q <= acc_rx_q + prod_q; acc_yx_q <= acc_yx_q + prod_q; end
        P_XX: begin acc_rx_q <= acc_rx_q - prod_q; acc_yx_q <= acc_yx_q + prod_q; end
        P_YY: begin acc_rx_q <= acc_rx_q - prod_q; acc_yx_q <= acc_yx_q - prod_q; end
        P_ZZ: begin acc_rx_q <= acc_rx_q + prod_q; acc_yx_q <= acc_yx_q - prod_q; end
        P_YZ, P_WX: acc_ry_q <= acc_ry_q + prod2;
        P_XY, P_WZ: acc_yy_q <= acc_yy_q + prod2;
        P_XZ:       acc_s_q  <= acc_s_q + prod2;
        default:    acc_s_q  <= acc_s_q - prod2;
      endcase
    end
  end

  // Floor shift by 30 and clamp of the asin argument
  logic signed [ArgW-1:0]  ry_q, rx_q, yy_q, yx_q;
  logic signed [CompW-1:0] s_q;
  logic signed [ArgW-1:0]  s_full;
  assign s_full = acc_s_q[AccW-1:30];

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      ry_q <= acc_ry_q[AccW-1:30];
      rx_q <= acc_rx_q[AccW-1:30];
      yy_q <= acc_yy_q[AccW-1:30];
      yx_q <= acc_yx_q[AccW-1:30];
      if (s_full > OneArg) s_q <= OneQ30;
      else if (s_full < -OneArg) s_q <= -OneQ30;
      else s_q <= s_full[CompW-1:0];
    end
  end

  // c = floor(sqrt(2^60 - s^2)), one result bit per cycle
  logic signed [AccW-1:0] sq_full;
  logic [SqW-1:0]         sq_q, rem_q, res_q, bit_q, trial;
  assign sq_full = s_q * s_q;
  assign trial   = res_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq) begin
      sq_q <= sq_full[SqW-1:0];
    end
    if (cmd_i.sqrt_init) begin
      rem_q <= (SqW'(1) << 60) - sq_q;
      res_q <= '0;
      bit_q <= SqW'(1) << 60;
    end else if (cmd_i.sqrt_step) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // CORDIC operand select
  logic signed [CxW-1:0] ax, ay;
  always_comb begin
    case (cmd_i.sel)
      SEL_ROLL:  begin ay = CxW'(ry_q); ax = CxW'(rx_q); end
      SEL_PITCH: begin ay = CxW'(s_q);  ax = $signed({{(CxW-31){1'b0}}, res_q[30:0]}); end
      default:   begin ay = CxW'(yy_q); ax = CxW'(yx_q); end
    endcase
  end

  // Shared vectoring CORDIC
  logic signed [CxW-1:0] cx_q, cy_q, xs, ys;
  logic signed [ZW-1:0]  cz_q, tab_v, tab0;
  logic                  zero_q;
  assign xs    = cx_q >>> cmd_i.step_idx;
  assign ys    = cy_q >>> cmd_i.step_idx;
  assign tab_v = atan_tab(cmd_i.step_idx);
  assign tab0  = atan_tab('0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cinit) begin
      zero_q <= (ax == '0) && (ay == '0);
      if (ax == '0 && ay == '0) begin
        cx_q <= '0;
        cy_q <= '0;
        cz_q <= '0;
      end else if (ax < 0) begin
        // pre-rotate by +/- pi/2 into the right half plane
        if (ay >= 0) begin
          cx_q <= ay;
          cy_q <= -ax;
          cz_q <= tab0 <<< 1;
        end else begin
          cx_q <= -ay;
          cy_q <= ax;
          cz_q <= -(tab0 <<< 1);
        end
      end else begin
        cx_q <= ax;
        cy_q <= ay;
        cz_q <= '0;
      end
    end else if (cmd_i.cstep && !zero_q) begin
      if (cy_q > 0) begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + tab_v;
      end else begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - tab_v;
      end
    end
  end

  // Scale to 10430 units per radian, truncating toward zero
  logic [ZW-1:0]   mag;
  logic [UPrW-1:0] uprod_q;
  logic            uneg_q;
  logic [17:0]     um;
  logic [18:0]     um_neg;
  logic signed [AngW-1:0] ang;
  assign mag = (cz_q < 0) ? ZW'(-cz_q) : ZW'(cz_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.umul) begin
      uprod_q <= UPrW'(mag) * UPrW'(UnitsPerRad);
      uneg_q  <= (cz_q < 0);
    end
  end

  assign um     = uprod_q[47:30];
  assign um_neg = 19'd0 - {1'b0, um};

  // Saturate to 16 bits
  always_comb begin
    if (!uneg_q) begin
      ang = (um > 18'd32767) ? 16'sh7FFF : $signed(um[15:0]);
    end else begin
      ang = (um > 18'd32768) ? 16'sh8000 : $signed(um_neg[15:0]);
    end
  end

  // Raw angles, offsets and output register
  logic signed [AngW-1:0] raw_roll_q, raw_pitch_q, raw_yaw_q;
  logic signed [AngW-1:0] off_roll_q, off_pitch_q, off_yaw_q;
  logic signed [AngW-1:0] out_roll_q, out_pitch_q, out_yaw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_roll_q  <= '0;
      raw_pitch_q <= '0;
      raw_yaw_q   <= '0;
      off_roll_q  <= '0;
      off_pitch_q <= '0;
      off_yaw_q   <= '0;
    end else begin
      if (cmd_i.ustore) begin
        case (cmd_i.sel)
          SEL_ROLL:  raw_roll_q  <= ang;
          SEL_PITCH: raw_pitch_q <= ang;
          default:   raw_yaw_q   <= ang;
        endcase
      end
      if (cmd_i.out_load && kind_q) begin
        off_roll_q  <= raw_roll_q;
        off_pitch_q <= raw_pitch_q;
        off_yaw_q   <= raw_yaw_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (kind_q) begin
        out_roll_q  <= '0;
        out_pitch_q <= '0;
        out_yaw_q   <= '0;
      end else begin
        out_roll_q  <= raw_roll_q - off_roll_q;
        out_pitch_q <= raw_pitch_q - off_pitch_q;
        out_yaw_q   <= raw_yaw_q - off_yaw_q;
      end
    end
  end

  assign roll_angle_o  = out_roll_q;
  assign pitch_angle_o = out_pitch_q;
  assign yaw_angle_o   = out_yaw_q;

endmodule

// File: hw/rtl/quaternion_to_euler_calibrated.sv
// Top level: quaternion to roll/pitch/yaw converter with zero-point calibration.
//
// Input channel (in_valid_i / in_stall_o): one transaction carries in_kind_i and a Q2.30
// quaternion. Kind 0 converts it, kind 1 copies the last raw angles into the offsets.
// Output channel (out_valid_o / out_stall_i): one transaction per input with roll, pitch
// and yaw in 10430 units per radian, raw angle minus offset, wrapping in 16 bits.
// A conversion runs the shared multiplier, the set-up, the square-root loop and, for each
// of the three angles, the shared CORDIC and its scaling, then loads the output register.
// A calibrate transaction skips all of these and only loads the output register.
// One item is in work at a time; the shared CORDIC and the square-root loop set the rate.
// The input is taken again as soon as the result sits in the output register, so the next
// item is processed while a result waits on a stalled receiver; a finished result waits
// only if the output register is still occupied.
// Reset clears the raw angles, the offsets and all control state; no clearing pass.
module quaternion_to_euler_calibrated import qte_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_kind_i,
  input  logic signed [31:0] in_q_w_i,
  input  logic signed [31:0] in_q_x_i,
  input  logic signed [31:0] in_q_y_i,
  input  logic signed [31:0] in_q_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o
);

  cmd_t cmd;

  // Controller
  qte_ctrl #(
    .CordicSteps (CORDIC_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_kind_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // Datapath
  qte_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .in_kind_i     (in_kind_i),
    .in_q_w_i      (in_q_w_i),
    .in_q_x_i      (in_q_x_i),
    .in_q_y_i      (in_q_y_i),
    .in_q_z_i      (in_q_z_i),
    .roll_angle_o  (roll_angle_o),
    .pitch_angle_o (pitch_angle_o),
    .yaw_angle_o   (yaw_angle_o)
  );

  // An accepted transaction always keeps the input stalled in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted again right after a transaction");

  // The output register is only overwritten once its transaction is gone
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("pending result overwritten");

  // Calibrate into an empty output register answers zeros once S_OUT has loaded the output register
  a_calib_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_kind_i && !out_valid_o) |=> ##1
    (out_valid_o && roll_angle_o == '0 && pitch_angle_o == '0 && yaw_angle_o == '0))
    else $error("calibrate transaction did not give a zero result");

endmodule
